FILE: design/fla_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lifo free list slot allocator
// no dependencies; used by fla_ctrl, fla_dp and the top level

package fla_pkg;

    localparam int SLOT_BYTES_W     = 13;
    localparam int SLOT_INDEX_W     = 9;
    localparam int GRANT_W          = 8;
    localparam int OFFSET_W         = 20;
    localparam int STATUS_W         = 2;

    localparam logic [SLOT_BYTES_W-1:0] SLOT_BYTES_RESET = 13'd64;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_POOL  = 2'd3;

    typedef struct packed {
        logic                    req_type;
        logic [SLOT_INDEX_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted_index;
        logic [OFFSET_W-1:0] data_offset;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage

FILE: design/fla_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/fla_ctrl.sv
`timescale 1ns / 1ps
// request sequencer: accept, then an execute state, then result strobe
// depends on fla_pkg

module fla_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output fla_pkg::dp_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

endmodule

FILE: design/fla_dp.sv
`timescale 1ns / 1ps
// datapath: free list head, untouched-slot watermark, link/free ram, result register
// depends on fla_pkg and fla_ram

module fla_dp #(
    parameter int POOL_SLOTS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fla_pkg::dp_cmd_t                    cmd,
    input  fla_pkg::req_t                       req,
    input  logic                                cfg_we,
    input  logic [fla_pkg::SLOT_BYTES_W-1:0]    cfg_wdata,
    output fla_pkg::rsp_t                       rsp
);

    localparam int AW = $clog2(POOL_SLOTS);
    // head and links also hold the null value POOL_SLOTS
    localparam int IW = $clog2(POOL_SLOTS + 1);
    localparam int CW = (IW > fla_pkg::SLOT_INDEX_W) ? IW : fla_pkg::SLOT_INDEX_W;
    localparam int PW = IW + fla_pkg::SLOT_BYTES_W;
    localparam int WW = IW + 1;
    localparam logic [IW-1:0] SLOT_NULL = IW'(POOL_SLOTS);

    logic [IW-1:0]                     head_reg;
    logic [IW-1:0]                     head_next;
    // slots at or above the watermark were never allocated: free, linked to i + 1
    logic [IW-1:0]                     mark_reg;
    logic [IW-1:0]                     mark_next;
    logic [fla_pkg::SLOT_BYTES_W-1:0]  slot_bytes_reg;
    fla_pkg::req_t                     req_reg;
    fla_pkg::rsp_t                     rsp_reg;
    fla_pkg::rsp_t                     rsp_next;

    logic [AW-1:0]  raddr;
    logic [WW-1:0]  rdata;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [WW-1:0]  wdata;

    logic           is_rel;
    logic           in_pool;
    logic [IW-1:0]  target;
    logic           untouched;
    logic           word_free;
    logic [IW-1:0]  word_next;
    logic [PW-1:0]  product;

    assign raddr = (req.req_type == fla_pkg::REQ_RELEASE) ? AW'(req.slot_index)
                                                          : AW'(head_reg);

    fla_ram #(
        .WIDTH (WW),
        .DEPTH (POOL_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.load),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign is_rel    = (req_reg.req_type == fla_pkg::REQ_RELEASE);
    assign in_pool   = (CW'(req_reg.slot_index) < CW'(POOL_SLOTS));
    assign target    = is_rel ? IW'(req_reg.slot_index) : head_reg;
    assign untouched = (target >= mark_reg);
    assign word_free = untouched ? 1'b1 : rdata[WW-1];
    assign word_next = untouched ? IW'(target + 1'b1) : rdata[IW-1:0];
    assign product   = PW'(head_reg) * PW'(slot_bytes_reg);

    always_comb
    begin
        head_next = head_reg;
        mark_next = mark_reg;
        we        = 1'b0;
        waddr     = AW'(target);
        wdata     = {1'b0, SLOT_NULL};
        rsp_next  = '0;
        if (!is_rel)
        begin
            if (head_reg == SLOT_NULL)
            begin
                rsp_next.status = fla_pkg::ST_EMPTY;
            end
            else
            begin
                rsp_next.status        = fla_pkg::ST_OK;
                rsp_next.granted_index = fla_pkg::GRANT_W'(head_reg);
                rsp_next.data_offset   = product[fla_pkg::OFFSET_W-1:0];
                we                     = cmd.exec;
                head_next              = word_next;
                if (untouched)
                begin
                    mark_next = IW'(mark_reg + 1'b1);
                end
            end
        end
        else if (!in_pool)
        begin
            rsp_next.status = fla_pkg::ST_NOT_IN_POOL;
        end
        else if (word_free)
        begin
            rsp_next.status = fla_pkg::ST_ALREADY_FREE;
        end
        else
        begin
            rsp_next.status = fla_pkg::ST_OK;
            we              = cmd.exec;
            wdata           = {1'b1, head_reg};
            head_next       = target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            mark_reg       <= '0;
            slot_bytes_reg <= fla_pkg::SLOT_BYTES_RESET;
        end
        else
        begin
            if (cmd.exec)
            begin
                head_reg <= head_next;
                mark_reg <= mark_next;
            end
            if (cfg_we)
            begin
                slot_bytes_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: design/free_list_slot_allocator_core.sv
`timescale 1ns / 1ps
// lifo free list slot allocator, top level
// start is taken into the execute state, which sets the registered done strobe
// start is ignored while busy; the execute state exists for the registered ram read
// reset: every slot free and chained in index order, head at slot 0, slot size 64 bytes;
// the link ram is never cleared, a watermark register stands in for untouched slots
// the receiver cannot stall: done is high for one cycle, rsp holds to the next result
// depends on fla_pkg, fla_ctrl, fla_dp, fla_ram

module free_list_slot_allocator_core #(
    parameter int POOL_SLOTS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  fla_pkg::req_t                    req,
    input  logic                             cfg_we,
    input  logic [fla_pkg::SLOT_BYTES_W-1:0] cfg_wdata,
    output logic                             done,
    output fla_pkg::rsp_t                    rsp
);

    fla_pkg::dp_cmd_t cmd;

    fla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    fla_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

endmodule

FILE: verif/fla_checker.sv
`timescale 1ns / 1ps
// scoreboard for the lifo free list slot allocator: tracks the free list and slot size,
// predicts each response from the request transfers and compares it with the block
// depends on fla_pkg

module fla_checker #(
    parameter int POOL_SLOTS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  fla_pkg::req_t                    req,
    input  logic                             cfg_we,
    input  logic [fla_pkg::SLOT_BYTES_W-1:0] cfg_wdata,
    input  logic                             done,
    input  fla_pkg::rsp_t                    rsp,
    output int                               errors,
    output int                               outstanding
);

    localparam logic [fla_pkg::SLOT_INDEX_W-1:0] SLOT_NULL =
        fla_pkg::SLOT_INDEX_W'(POOL_SLOTS);

    logic [fla_pkg::SLOT_INDEX_W-1:0] next_link [POOL_SLOTS];
    logic                             slot_is_free [POOL_SLOTS];
    logic [fla_pkg::SLOT_INDEX_W-1:0] list_head;
    logic [fla_pkg::SLOT_BYTES_W-1:0] slot_size;
    fla_pkg::rsp_t                    expected_rsp [$];

    // pops or pushes the list head when the request succeeds and returns the response the block owes
    function automatic fla_pkg::rsp_t serve_request(input fla_pkg::req_t r);
        fla_pkg::rsp_t                    o;
        logic [fla_pkg::SLOT_INDEX_W-1:0] h;
        logic [31:0]                      product;
        o = '0;
        if (r.req_type == fla_pkg::REQ_ALLOC)
        begin
            h = list_head;
            if (h >= SLOT_NULL)
            begin
                o.status = fla_pkg::ST_EMPTY;
            end
            else
            begin
                list_head = (next_link[h] > SLOT_NULL) ? SLOT_NULL : next_link[h];
                next_link[h] = SLOT_NULL;
                slot_is_free[h] = 1'b0;
                product = 32'(h) * 32'(slot_size);
                o.status = fla_pkg::ST_OK;
                o.granted_index = h[fla_pkg::GRANT_W-1:0];
                o.data_offset = product[fla_pkg::OFFSET_W-1:0];
            end
        end
        else if (r.slot_index >= SLOT_NULL)
        begin
            o.status = fla_pkg::ST_NOT_IN_POOL;
        end
        else if (slot_is_free[r.slot_index])
        begin
            o.status = fla_pkg::ST_ALREADY_FREE;
        end
        else
        begin
            slot_is_free[r.slot_index] = 1'b1;
            next_link[r.slot_index] = list_head;
            list_head = r.slot_index;
            o.status = fla_pkg::ST_OK;
        end
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fla_pkg::rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                next_link[i] = fla_pkg::SLOT_INDEX_W'(i + 1);
                slot_is_free[i] = 1'b1;
            end
            list_head = '0;
            slot_size = fla_pkg::SLOT_BYTES_RESET;
            expected_rsp.delete();
            errors = 0;
        end
        else
        begin
            // retire the oldest expectation before queueing a new transfer
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected response status %0d index %0d",
                                              rsp.status, rsp.granted_index));
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  rsp.status, want.status));
                    if (rsp.granted_index !== want.granted_index)
                        report_mismatch($sformatf("granted_index got %0d expected %0d",
                                                  rsp.granted_index, want.granted_index));
                    if (rsp.data_offset !== want.data_offset)
                        report_mismatch($sformatf("data_offset got %0h expected %0h",
                                                  rsp.data_offset, want.data_offset));
                end
            end
            if (cfg_we)
                slot_size = cfg_wdata;
            if (start && !busy)
                expected_rsp.push_back(serve_request(req));
        end
        outstanding = expected_rsp.size();
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// testbench top for free_list_slot_allocator_core: drives request and slot size writes,
// keeps the list of granted slots for releases; checking lives in fla_checker
// depends on fla_pkg, fla_checker and the design

module tb;

    localparam int POOL_SLOTS = 256;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    fla_pkg::req_t                    req;
    logic                             cfg_we;
    logic [fla_pkg::SLOT_BYTES_W-1:0] cfg_wdata;
    logic                             done;
    fla_pkg::rsp_t                    rsp;
    int                               errors;
    int                               outstanding;

    logic [fla_pkg::GRANT_W-1:0] held_slots [$];
    logic                        issued_kind [$];
    logic                        kind;
    logic                        saw_empty;
    int                          n_grant, n_freed, n_empty, n_double, n_outside, n_issued;

    free_list_slot_allocator_core #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .done     (done),
        .rsp      (rsp)
    );

    fla_checker #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .rsp        (rsp),
        .errors     (errors),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d responses outstanding", outstanding);
        $display("Test completed with failures");
        $finish;
    end

    // collect granted slots so that releases mostly hit slots in use
    always @(posedge clk)
    begin
        if (rst_n && done && issued_kind.size() > 0)
        begin
            kind = issued_kind.pop_front();
            case (rsp.status)
                fla_pkg::ST_OK:
                begin
                    if (kind == fla_pkg::REQ_ALLOC)
                    begin
                        held_slots.push_back(rsp.granted_index);
                        n_grant++;
                    end
                    else
                    begin
                        n_freed++;
                    end
                end
                fla_pkg::ST_EMPTY:
                begin
                    saw_empty = 1'b1;
                    n_empty++;
                end
                fla_pkg::ST_ALREADY_FREE: n_double++;
                default:                  n_outside++;
            endcase
        end
        if (rst_n && start && !busy)
            issued_kind.push_back(req.req_type);
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic issue(input logic rtype, input logic [fla_pkg::SLOT_INDEX_W-1:0] idx);
        fla_pkg::req_t r;
        r.req_type = rtype;
        r.slot_index = idx;
        req <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        n_issued++;
    endtask

    task automatic release_slot(input logic [fla_pkg::SLOT_INDEX_W-1:0] idx);
        for (int i = 0; i < held_slots.size(); i++)
        begin
            if (idx < POOL_SLOTS && held_slots[i] == idx[fla_pkg::GRANT_W-1:0])
            begin
                held_slots.delete(i);
                break;
            end
        end
        issue(fla_pkg::REQ_RELEASE, idx);
    endtask

    task automatic release_held();
        int pick;
        logic [fla_pkg::SLOT_INDEX_W-1:0] s;
        pick = $urandom_range(0, held_slots.size() - 1);
        s = fla_pkg::SLOT_INDEX_W'(held_slots[pick]);
        held_slots.delete(pick);
        issue(fla_pkg::REQ_RELEASE, s);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge clk); while (outstanding != 0 || busy);
    endtask

    task automatic write_slot_bytes(input logic [fla_pkg::SLOT_BYTES_W-1:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_request(input logic filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            // noise: any index, inside or outside the pool
            if (roll < 3)
                issue(fla_pkg::REQ_ALLOC, fla_pkg::SLOT_INDEX_W'($urandom_range(0, 511)));
            else
                release_slot(fla_pkg::SLOT_INDEX_W'($urandom_range(0, 511)));
        end
        else if ((filling ? roll < 88 : roll < 20) || held_slots.size() == 0)
        begin
            issue(fla_pkg::REQ_ALLOC, fla_pkg::SLOT_INDEX_W'($urandom_range(0, 511)));
        end
        else
        begin
            release_held();
        end
    endtask

    initial
    begin
        logic [fla_pkg::SLOT_BYTES_W-1:0] sizes [8];
        int                               idle_pct [4];
        logic                             fill_mode;
        int                               drain_floor;
        int                               guard;
        sizes = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd4097, 13'd64, 13'd3, 13'd0};
        sizes[7] = fla_pkg::SLOT_BYTES_W'($urandom_range(1, 8191));
        // the third phase would be receiver stall, which this interface cannot express
        idle_pct = '{0, 65, 0, 32};
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        saw_empty = 1'b0;
        n_grant = 0;
        n_freed = 0;
        n_empty = 0;
        n_double = 0;
        n_outside = 0;
        n_issued = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset chain, lifo reuse, double release, out of pool indexes, slot sizes 8191 and 0
        issue(fla_pkg::REQ_ALLOC, 9'h1FF);
        issue(fla_pkg::REQ_ALLOC, 9'h000);
        release_slot(9'd0);
        release_slot(9'd0);
        release_slot(9'd511);
        release_slot(9'd256);
        release_slot(9'd255);
        issue(fla_pkg::REQ_ALLOC, 9'h0AA);
        issue(fla_pkg::REQ_ALLOC, 9'h155);
        release_slot(9'd1);
        release_slot(9'd2);
        issue(fla_pkg::REQ_ALLOC, 9'h000);
        issue(fla_pkg::REQ_ALLOC, 9'h000);
        write_slot_bytes(13'd8191);
        issue(fla_pkg::REQ_ALLOC, 9'h000);
        write_slot_bytes(13'd0);
        issue(fla_pkg::REQ_ALLOC, 9'h000);
        release_slot(9'd3);

        // random: fill toward empty, then drain part way, with noise throughout
        fill_mode = 1'b1;
        drain_floor = 0;
        for (int p = 0; p < 8; p++)
        begin
            write_slot_bytes(sizes[p]);
            for (int k = 0; k < 240; k++)
            begin
                if (fill_mode && (saw_empty || held_slots.size() >= POOL_SLOTS))
                begin
                    fill_mode = 1'b0;
                    drain_floor = $urandom_range(0, 60);
                end
                else if (!fill_mode && held_slots.size() <= drain_floor)
                begin
                    fill_mode = 1'b1;
                    saw_empty = 1'b0;
                end
                random_request(fill_mode);
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
                else if ($urandom_range(0, 99) < idle_pct[p % 4])
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(negedge clk);
                end
            end
        end

        start <= 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < 2000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
        if (outstanding != 0)
            $display("%0d expected responses never arrived", outstanding);
        $display("%0d requests: %0d grants, %0d releases, %0d empty pool", n_issued, n_grant,
                 n_freed, n_empty);
        $display("%0d double releases, %0d outside pool, 10 slot sizes incl 0 and 8191",
                 n_double, n_outside);
        if (errors == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
